@@ rtl/mmpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mmpr_pkg
// Shared types and constants for the mono mix phase resampler: field widths,
// register indexes, reset values, controller states and the command and
// status groups between controller and datapath.
// ----------------------------------------------------------------------------
package mmpr_pkg;

  // Field widths
  localparam int NUM_CHAN  = 8;   // channel sample ports on the frame
  localparam int SAMPLE_W  = 24;  // signed Q0.23 sample
  localparam int SUM_W     = SAMPLE_W + 3;  // sum of up to eight samples
  localparam int PCM_W     = 16;
  localparam int PHASE_W   = 21;  // unsigned Q5.16 phase, masked
  localparam int WORK_W    = PHASE_W + 1;  // phase plus one ratio step
  localparam int FRAC_W    = 16;  // fraction bits of the phase
  localparam int CNT_W     = 4;   // channel_count register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 21;  // widest register

  // Conversion: pcm = |sum| * 32767 / (n * 2^23), quotient below 2^15
  localparam int PCM_SHIFT = 15;  // 32767 = 2^15 - 1
  localparam int FULL_SHIFT = SAMPLE_W - 1;
  localparam int PROD_W    = SUM_W + PCM_SHIFT;
  localparam int DIVD_W    = PROD_W - FULL_SHIFT - 1;  // scaled magnitude
  localparam int QUO_W     = 15;
  localparam int REM_W     = 3;   // remainder below n, n at most eight
  localparam int STEP_W    = 4;

  // Emission limits
  localparam int MAX_RESULTS = 16;
  localparam int EMIT_W      = 5;

  // Default for the top-level parameter
  localparam int MAX_CHANNELS_DEF = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_RATIO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_ENABLE   = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RST = 4'd1;
  localparam logic [PHASE_W-1:0] RATE_RATIO_RST    = 21'd131072;
  localparam logic               MUTE_ENABLE_RST   = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DIVIDE,
    ST_EMIT
  } mmpr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch frame sum and flags, load working phase
    logic mix;       // scale magnitude and load divider
    logic div_step;  // one quotient bit
    logic emit;      // load output register, advance phase
    logic finish;    // commit phase after the emission loop
  } mmpr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;      // frame on the input port is to be dropped
    logic div_last;  // current divide step is the final one
    logic emit_ok;   // phase below one and result limit not reached
  } mmpr_status_t;

endpackage

@@ rtl/mmpr_datapath.sv @@
// ----------------------------------------------------------------------------
// mmpr_datapath
// Configuration registers, channel mix, restoring divider by the channel
// count, phase accumulator and output register.
// ----------------------------------------------------------------------------
module mmpr_datapath #(
  parameter int MAX_CHANNELS = mmpr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [mmpr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mmpr_pkg::CFG_W-1:0]            cfg_data,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0]  chans [mmpr_pkg::NUM_CHAN],
  input  logic                                  link_up,
  input  logic                                  assistant_busy,
  input  mmpr_pkg::mmpr_cmd_t                   cmd,
  output mmpr_pkg::mmpr_status_t                status,
  output logic signed [mmpr_pkg::PCM_W-1:0]     pcm_sample,
  output logic                                  last_of_frame
);

  localparam int ChanLimit = (MAX_CHANNELS < mmpr_pkg::NUM_CHAN) ?
                             MAX_CHANNELS : mmpr_pkg::NUM_CHAN;
  localparam logic [mmpr_pkg::WORK_W-1:0] PhaseOne =
    mmpr_pkg::WORK_W'(1) << mmpr_pkg::FRAC_W;

  // Configuration registers
  logic [mmpr_pkg::CNT_W-1:0]   channel_count;
  logic [mmpr_pkg::PHASE_W-1:0] rate_ratio;
  logic                         mute_enable;

  // Frame and divider state
  logic signed [mmpr_pkg::SUM_W-1:0] sum;
  logic                              neg;
  logic                              n_zero;
  logic [mmpr_pkg::REM_W-1:0]        rem;
  logic [mmpr_pkg::QUO_W-1:0]        dsh;
  logic [mmpr_pkg::QUO_W-1:0]        quo;
  logic [mmpr_pkg::STEP_W-1:0]       step;

  // Phase state
  logic [mmpr_pkg::PHASE_W-1:0] resample_phase;
  logic [mmpr_pkg::WORK_W-1:0]  work;
  logic [mmpr_pkg::EMIT_W-1:0]  emit_cnt;

  logic [mmpr_pkg::CNT_W-1:0]        n_active;
  logic signed [mmpr_pkg::SUM_W-1:0] sum_comb;
  logic [mmpr_pkg::SUM_W-1:0]        mag;
  logic [mmpr_pkg::PROD_W-1:0]       prod;
  logic [mmpr_pkg::DIVD_W-1:0]       scaled;
  logic [mmpr_pkg::CNT_W-1:0]        trial;
  logic                              trial_ge;
  logic signed [mmpr_pkg::PCM_W-1:0] pcm_val;
  logic [mmpr_pkg::WORK_W-1:0]       work_next;

  // Configuration writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= mmpr_pkg::CHANNEL_COUNT_RST;
      rate_ratio    <= mmpr_pkg::RATE_RATIO_RST;
      mute_enable   <= mmpr_pkg::MUTE_ENABLE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        mmpr_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[mmpr_pkg::CNT_W-1:0];
        mmpr_pkg::CFG_RATE_RATIO:    rate_ratio    <= cfg_data[mmpr_pkg::PHASE_W-1:0];
        mmpr_pkg::CFG_MUTE_ENABLE:   mute_enable   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Active channel count, saturated to the port count and parameter
  always_comb begin
    if (channel_count > mmpr_pkg::CNT_W'(ChanLimit)) begin
      n_active = mmpr_pkg::CNT_W'(ChanLimit);
    end else begin
      n_active = channel_count;
    end
  end

  // Masked sum of the active channels
  always_comb begin
    sum_comb = '0;
    for (int c = 0; c < mmpr_pkg::NUM_CHAN; c++) begin
      if (mmpr_pkg::CNT_W'(c) < n_active) begin
        sum_comb = sum_comb + mmpr_pkg::SUM_W'(chans[c]);
      end
    end
  end

  // Magnitude times 32767 by shift and subtract, then drop the Q0.23 scale
  always_comb begin
    mag    = sum[mmpr_pkg::SUM_W-1] ? mmpr_pkg::SUM_W'(-sum) : mmpr_pkg::SUM_W'(sum);
    prod   = (mmpr_pkg::PROD_W'(mag) << mmpr_pkg::PCM_SHIFT) - mmpr_pkg::PROD_W'(mag);
    scaled = prod[mmpr_pkg::PROD_W-2:mmpr_pkg::FULL_SHIFT];
  end

  // Divider trial subtraction
  always_comb begin
    trial    = {rem, dsh[mmpr_pkg::QUO_W-1]};
    trial_ge = (trial >= n_active);
  end

  // Frame latch and divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum    <= sum_comb;
      n_zero <= (n_active == '0);
    end
    if (cmd.mix) begin
      neg  <= sum[mmpr_pkg::SUM_W-1];
      rem  <= scaled[mmpr_pkg::DIVD_W-1:mmpr_pkg::QUO_W];
      dsh  <= scaled[mmpr_pkg::QUO_W-1:0];
      quo  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      rem  <= trial_ge ? mmpr_pkg::REM_W'(trial - n_active) : mmpr_pkg::REM_W'(trial);
      dsh  <= {dsh[mmpr_pkg::QUO_W-2:0], 1'b0};
      quo  <= {quo[mmpr_pkg::QUO_W-2:0], trial_ge};
      step <= step + 1'b1;
    end
  end

  // Signed result; quotient fits 15 bits so it never passes +-32767
  always_comb begin
    if (n_zero) begin
      pcm_val = '0;
    end else if (neg) begin
      pcm_val = -$signed({1'b0, quo});
    end else begin
      pcm_val = $signed({1'b0, quo});
    end
  end

  assign work_next = work + mmpr_pkg::WORK_W'(rate_ratio);

  // Phase accumulator and emission counter
  always_ff @(posedge clk) begin
    if (rst) begin
      resample_phase <= '0;
    end else if (cmd.finish) begin
      if (work >= PhaseOne) begin
        resample_phase <= mmpr_pkg::PHASE_W'(work - PhaseOne);
      end else begin
        resample_phase <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      work     <= mmpr_pkg::WORK_W'(resample_phase);
      emit_cnt <= '0;
    end else if (cmd.emit) begin
      work     <= work_next;
      emit_cnt <= emit_cnt + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pcm_sample    <= pcm_val;
      last_of_frame <= (work_next >= PhaseOne) ||
                       (emit_cnt == mmpr_pkg::EMIT_W'(mmpr_pkg::MAX_RESULTS - 1));
    end
  end

  // Status to the controller
  always_comb begin
    status.drop     = !link_up || (mute_enable && assistant_busy);
    status.div_last = (step == mmpr_pkg::STEP_W'(mmpr_pkg::QUO_W - 1));
    status.emit_ok  = (work < PhaseOne) &&
                      (emit_cnt < mmpr_pkg::EMIT_W'(mmpr_pkg::MAX_RESULTS));
  end

endmodule

@@ rtl/mmpr_controller.sv @@
// ----------------------------------------------------------------------------
// mmpr_controller
// Frame sequencer: accept, mix, divide, emission loop. Owns the input ready
// and the output valid flag.
// ----------------------------------------------------------------------------
module mmpr_controller (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mmpr_pkg::mmpr_status_t status,
  output mmpr_pkg::mmpr_cmd_t    cmd
);

  mmpr_pkg::mmpr_state_t state, state_next;
  logic                  out_valid_next;
  logic                  out_free;

  assign out_free = !out_valid || out_ready;

  // State register and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mmpr_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mmpr_pkg::ST_IDLE: begin
        if (in_valid && !status.drop) state_next = mmpr_pkg::ST_MIX;
      end
      mmpr_pkg::ST_MIX: state_next = mmpr_pkg::ST_DIVIDE;
      mmpr_pkg::ST_DIVIDE: begin
        if (status.div_last) state_next = mmpr_pkg::ST_EMIT;
      end
      mmpr_pkg::ST_EMIT: begin
        if (!status.emit_ok) state_next = mmpr_pkg::ST_IDLE;
      end
      default: state_next = mmpr_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      mmpr_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid && !status.drop;
      end
      mmpr_pkg::ST_MIX:    cmd.mix = 1'b1;
      mmpr_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
      mmpr_pkg::ST_EMIT: begin
        if (!status.emit_ok) begin
          cmd.finish = 1'b1;
        end else if (out_free) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/mono_mix_phase_resampler.sv @@
// ----------------------------------------------------------------------------
// mono_mix_phase_resampler
// Mixes a capture frame of up to eight Q0.23 channels to 16-bit mono PCM and
// resamples it by nearest neighbor with a Q5.16 phase accumulator.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_write with cfg_index 0 (channel_count), 1 (rate_ratio)
//   or 2 (mute_enable) and cfg_data; write only while the block is idle.
//   Input: one frame per in_valid/in_ready transfer. A frame with link_up low,
//   or with assistant_busy high while mute is enabled, is dropped in its
//   transfer cycle and in_ready stays high.
//   Output: zero to sixteen pcm_sample transfers per frame over
//   out_valid/out_ready; last_of_frame marks the final one.
//   Sequence: after a frame transfer come the mix step and a divide of fifteen
//   quotient bits (one quotient bit per cycle, division by the channel count),
//   then the emission loop, which emits the samples one after another, and a
//   final step that commits the phase.
//   Backpressure: the output register holds a sample until it is taken; the
//   emission loop waits on it, and the next frame may be taken while the
//   last sample of the previous one is still held.
//   Reset: rst clears the phase, loads register defaults (one channel,
//   ratio 2.0, mute on) and empties the output register.
// ----------------------------------------------------------------------------
module mono_mix_phase_resampler #(
  parameter int MAX_CHANNELS = mmpr_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mmpr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mmpr_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan0,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan1,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan2,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan3,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan4,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan5,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan6,
  input  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan7,
  input  logic                                 link_up,
  input  logic                                 assistant_busy,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mmpr_pkg::PCM_W-1:0]    pcm_sample,
  output logic                                 last_of_frame
);

  logic signed [mmpr_pkg::SAMPLE_W-1:0] chans [mmpr_pkg::NUM_CHAN];
  mmpr_pkg::mmpr_cmd_t                  cmd;
  mmpr_pkg::mmpr_status_t               status;

  // Channel ports gathered for the mixer
  assign chans[0] = chan0;
  assign chans[1] = chan1;
  assign chans[2] = chan2;
  assign chans[3] = chan3;
  assign chans[4] = chan4;
  assign chans[5] = chan5;
  assign chans[6] = chan6;
  assign chans[7] = chan7;

  mmpr_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mmpr_datapath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .chans          (chans),
    .link_up        (link_up),
    .assistant_busy (assistant_busy),
    .cmd            (cmd),
    .status         (status),
    .pcm_sample     (pcm_sample),
    .last_of_frame  (last_of_frame)
  );

endmodule

@@ rtl/mmpr_checker.sv @@
// ----------------------------------------------------------------------------
// mmpr_checker
// Port-level checks for the mono mix phase resampler, bound to the top level.
// ----------------------------------------------------------------------------
module mmpr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              link_up,
  input logic                              assistant_busy,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [mmpr_pkg::PCM_W-1:0] pcm_sample,
  input logic                              last_of_frame
);

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled sample holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pcm_sample) &&
                                $stable(last_of_frame))
    else $error("stalled output changed");

  // Samples never reach the negative full-scale code
  a_pcm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pcm_sample != 16'sh8000)
    else $error("pcm_sample out of range");

  // A frame with the link down is dropped at once
  a_drop_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !link_up |=> in_ready)
    else $error("dropped frame left the block busy");

  // A frame that passes the gates starts processing
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && link_up && !assistant_busy |=> !in_ready)
    else $error("kept frame did not start processing");

endmodule

bind mono_mix_phase_resampler mmpr_checker u_mmpr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .link_up        (link_up),
  .assistant_busy (assistant_busy),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .pcm_sample     (pcm_sample),
  .last_of_frame  (last_of_frame)
);

@@ tb/mono_mix_phase_resampler_test.sv @@
// ----------------------------------------------------------------------------
// mono_mix_phase_resampler_test
// Self-checking bench for the mono mix phase resampler. Frames are queued by
// the stimulus process and sent by a bursty driver. Each frame transfer runs
// through a local mixer and phase accumulator, and the expected PCM samples
// are compared in order against the output transfers while the receiver
// stalls at random. Register settings change only between phases, once the
// block has drained.
// ----------------------------------------------------------------------------
module mono_mix_phase_resampler_test;

  localparam int           SETTLE_CYCLES = 40;     // one full frame plus slack
  localparam int           HOLD_CYCLES   = 400;    // long receiver hold-off
  localparam int           PCM_FULL      = 32767;
  localparam int unsigned  PHASE_ONE     = 65536;
  localparam longint       Q23_ONE       = 64'sd8388608;
  localparam logic [mmpr_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register here

  typedef struct packed {
    logic [mmpr_pkg::NUM_CHAN-1:0][mmpr_pkg::SAMPLE_W-1:0] ch;
    logic                                                  link;
    logic                                                  busy;
  } frame_t;

  typedef struct packed {
    logic signed [mmpr_pkg::PCM_W-1:0] pcm;
    logic                              last;
  } pcm_result_t;

  // DUT ports
  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_write = 1'b0;
  logic [mmpr_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [mmpr_pkg::CFG_W-1:0]           cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan0 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan1 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan2 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan3 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan4 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan5 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan6 = '0;
  logic signed [mmpr_pkg::SAMPLE_W-1:0] chan7 = '0;
  logic                                 link_up = 1'b0;
  logic                                 assistant_busy = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic signed [mmpr_pkg::PCM_W-1:0]    pcm_sample;
  logic                                 last_of_frame;

  // Pending frames, expected samples, local copy of the block's state
  frame_t                         frame_q[$];
  pcm_result_t                    pcm_expect_q[$];
  logic [mmpr_pkg::CNT_W-1:0]     cur_chan_count = mmpr_pkg::CHANNEL_COUNT_RST;
  logic [mmpr_pkg::PHASE_W-1:0]   cur_ratio      = mmpr_pkg::RATE_RATIO_RST;
  logic                           cur_mute       = mmpr_pkg::MUTE_ENABLE_RST;
  logic [mmpr_pkg::PHASE_W-1:0]   phase_acc      = '0;
  int                             mismatch_count = 0;

  // Sender and receiver pacing
  int   burst_left = 0;
  int   gap_left   = 0;
  int   stall_pct  = 0;
  int   mode_left  = 0;
  int   hold_left  = 0;
  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;

  mono_mix_phase_resampler u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .chan0          (chan0),
    .chan1          (chan1),
    .chan2          (chan2),
    .chan3          (chan3),
    .chan4          (chan4),
    .chan5          (chan5),
    .chan6          (chan6),
    .chan7          (chan7),
    .link_up        (link_up),
    .assistant_busy (assistant_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pcm_sample     (pcm_sample),
    .last_of_frame  (last_of_frame)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mix one frame to mono PCM and step the phase; queue the expected samples
  function automatic void resample_frame(frame_t f);
    longint      sum;
    longint      q;
    longint      n;
    int unsigned ph;
    int          cnt;
    int          c;
    pcm_result_t r;
    if (!f.link || (cur_mute && f.busy)) return;  // dropped, phase untouched
    n = (cur_chan_count > mmpr_pkg::NUM_CHAN) ? mmpr_pkg::NUM_CHAN : cur_chan_count;
    sum = 0;
    for (c = 0; c < n; c++) sum += longint'($signed(f.ch[c]));
    if (n == 0) q = 0;
    else q = (sum * PCM_FULL) / (n * Q23_ONE);  // truncates toward zero
    if (q > PCM_FULL) q = PCM_FULL;
    if (q < -PCM_FULL) q = -PCM_FULL;
    // count the samples first so the final one can be flagged
    ph = phase_acc;
    cnt = 0;
    while (ph < PHASE_ONE && cnt < mmpr_pkg::MAX_RESULTS) begin
      cnt++;
      ph += cur_ratio;
    end
    for (c = 0; c < cnt; c++) begin
      r.pcm = mmpr_pkg::PCM_W'(q);
      r.last = (c == cnt - 1);
      pcm_expect_q.push_back(r);
    end
    // ratio too small to reach one within the limit: phase saturates to zero
    if (ph >= PHASE_ONE) ph -= PHASE_ONE;
    else ph = 0;
    phase_acc = mmpr_pkg::PHASE_W'(ph);
  endfunction

  // Frame driver: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_ready)) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (frame_q.size() != 0) begin
        frame_t f;
        f = frame_q.pop_front();
        chan0 <= f.ch[0];
        chan1 <= f.ch[1];
        chan2 <= f.ch[2];
        chan3 <= f.ch[3];
        chan4 <= f.ch[4];
        chan5 <= f.ch[5];
        chan6 <= f.ch[6];
        chan7 <= f.ch[7];
        link_up <= f.link;
        assistant_busy <= f.busy;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall rate changes per segment, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 50;
          default: stall_pct <= 80;
        endcase
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Output checking, then prediction for a frame transfer in the same cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pcm_expect_q.size() == 0) begin
          $display("%0t: unexpected sample pcm=%0d last=%0b", $time, pcm_sample,
                   last_of_frame);
          mismatch_count++;
        end else begin
          pcm_result_t e;
          e = pcm_expect_q.pop_front();
          if (pcm_sample !== e.pcm) begin
            $display("%0t: pcm_sample expected %0d actual %0d", $time, e.pcm,
                     pcm_sample);
            mismatch_count++;
          end
          if (last_of_frame !== e.last) begin
            $display("%0t: last_of_frame expected %0b actual %0b", $time, e.last,
                     last_of_frame);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        frame_t f;
        f.ch = {chan7, chan6, chan5, chan4, chan3, chan2, chan1, chan0};
        f.link = link_up;
        f.busy = assistant_busy;
        resample_frame(f);
      end
    end
  end

  // Register write; the local copy follows with the same masking
  task automatic write_reg(input logic [mmpr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mmpr_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      mmpr_pkg::CFG_CHANNEL_COUNT: cur_chan_count = val[mmpr_pkg::CNT_W-1:0];
      mmpr_pkg::CFG_RATE_RATIO:    cur_ratio = val[mmpr_pkg::PHASE_W-1:0];
      mmpr_pkg::CFG_MUTE_ENABLE:   cur_mute = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every frame is sent and every sample has come, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (frame_q.size() != 0 || in_valid || pcm_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [mmpr_pkg::SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return '0;
      3: return mmpr_pkg::SAMPLE_W'($urandom_range(1, 255));
      4: return -mmpr_pkg::SAMPLE_W'($urandom_range(1, 255));
      default: return mmpr_pkg::SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    int     c;
    for (c = 0; c < mmpr_pkg::NUM_CHAN; c++) f.ch[c] = rand_sample();
    f.link = ($urandom_range(0, 9) != 0);
    f.busy = ($urandom_range(0, 9) < 3);
    return f;
  endfunction

  function automatic void push_uniform(logic [mmpr_pkg::SAMPLE_W-1:0] s, logic link,
                                       logic busy);
    frame_t f;
    int     c;
    for (c = 0; c < mmpr_pkg::NUM_CHAN; c++) f.ch[c] = s;
    f.link = link;
    f.busy = busy;
    frame_q.push_back(f);
  endfunction

  // Stimulus
  initial begin
    int          ph_idx;
    int          k;
    int          n_frames;
    logic [3:0]  cnt_val;
    logic [20:0] ratio_val;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: one channel, ratio 2.0, mute on
    push_uniform(24'h7FFFFF, 1'b1, 1'b0);
    push_uniform(24'h800000, 1'b1, 1'b0);  // phase at one on entry
    push_uniform(24'h000000, 1'b1, 1'b0);
    push_uniform(24'h123456, 1'b0, 1'b0);  // link down
    push_uniform(24'h654321, 1'b1, 1'b1);  // muted
    push_uniform(24'h800000, 1'b0, 1'b1);
    frame_q.push_back(rand_frame());
    wait_idle();

    // All eight channels, smallest legal ratio, mute off; upper data bits set
    write_reg(mmpr_pkg::CFG_CHANNEL_COUNT, 21'h1FFFF8);
    write_reg(mmpr_pkg::CFG_RATE_RATIO, 21'd4096);
    write_reg(mmpr_pkg::CFG_MUTE_ENABLE, 21'h1FFFFE);
    write_reg(CFG_UNUSED, 21'h1FFFFF);  // must not touch any register
    @(negedge clk);
    push_uniform(24'h7FFFFF, 1'b1, 1'b0);
    push_uniform(24'h800000, 1'b1, 1'b0);
    push_uniform(24'h400000, 1'b1, 1'b1);  // busy passes with mute off
    wait_idle();

    // Zero channels and zero ratio: sixteen zero samples, phase saturates
    write_reg(mmpr_pkg::CFG_CHANNEL_COUNT, 21'd0);
    write_reg(mmpr_pkg::CFG_RATE_RATIO, 21'd0);
    @(negedge clk);
    frame_q.push_back(rand_frame());
    push_uniform(24'h7FFFFF, 1'b1, 1'b0);
    wait_idle();

    // Count above eight, ratio 16.0: long runs of frames with no samples
    write_reg(mmpr_pkg::CFG_CHANNEL_COUNT, 21'h1FFFFF);
    write_reg(mmpr_pkg::CFG_RATE_RATIO, 21'd1048576);
    write_reg(mmpr_pkg::CFG_MUTE_ENABLE, 21'd1);
    @(negedge clk);
    push_uniform(24'h7FFFFF, 1'b1, 1'b0);
    for (k = 0; k < 4; k++) frame_q.push_back(rand_frame());
    wait_idle();

    // Random phases, each with its own register settings
    for (ph_idx = 0; ph_idx < 12; ph_idx++) begin
      case ($urandom_range(0, 9))
        0: cnt_val = 4'd0;
        1: cnt_val = 4'($urandom_range(9, 15));
        2: cnt_val = 4'd8;
        default: cnt_val = 4'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 19))
        0: ratio_val = 21'($urandom_range(0, 4095));
        1: ratio_val = 21'($urandom_range(1048577, 21'h1FFFFF));
        2: ratio_val = 21'h1FFFFF;
        3: ratio_val = 21'd1048576;
        4, 5, 6: ratio_val = 21'd4096;
        7, 8: ratio_val = 21'($urandom_range(4096, 1048576));
        default: ratio_val = 21'($urandom_range(16384, 262144));
      endcase
      if (ph_idx == 3) ratio_val = 21'd8192;  // many samples per frame for the hold
      write_reg(mmpr_pkg::CFG_CHANNEL_COUNT, {17'($urandom()), cnt_val});
      write_reg(mmpr_pkg::CFG_RATE_RATIO, ratio_val);
      write_reg(mmpr_pkg::CFG_MUTE_ENABLE, 21'($urandom()));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 21'($urandom()));
      @(negedge clk);
      n_frames = $urandom_range(22, 30);
      for (k = 0; k < n_frames; k++) frame_q.push_back(rand_frame());
      if (ph_idx == 3) hold_req = 1'b1;  // receiver holds while frames keep coming
      wait_idle();
    end

    if (pcm_expect_q.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time, pcm_expect_q.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
